// File: rtl/mlfqss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mlfqss_pkg;

    localparam int DEF_NUM_SLOTS = 64;
    localparam int DEF_FRAC_BITS = 16;
    localparam int FULL_SHARE    = 100;

    localparam logic [2:0] MODE_ADMIT = 3'd0;
    localparam logic [2:0] MODE_BLOCK = 3'd1;
    localparam logic [2:0] MODE_WAKE  = 3'd2;
    localparam logic [2:0] MODE_SCHED = 3'd3;
    localparam logic [2:0] MODE_SHARE = 3'd4;
    localparam logic [2:0] MODE_EXIT  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_NONE     = 2'd2;
    localparam logic [1:0] ST_NOT_USED = 2'd3;

    localparam logic [2:0] CFG_BOOST_PERIOD = 3'd0;
    localparam logic [2:0] CFG_ALLOT0       = 3'd1;
    localparam logic [2:0] CFG_ALLOT1       = 3'd2;
    localparam logic [2:0] CFG_QUANTUM0     = 3'd3;
    localparam logic [2:0] CFG_QUANTUM1     = 3'd4;
    localparam logic [2:0] CFG_QUANTUM2     = 3'd5;
    localparam logic [2:0] CFG_MIN_SHARE    = 3'd6;

    localparam logic [15:0] RST_BOOST_PERIOD = 16'd100;
    localparam logic [7:0]  RST_ALLOT0       = 8'd5;
    localparam logic [7:0]  RST_ALLOT1       = 8'd10;
    localparam logic [7:0]  RST_QUANTUM0     = 8'd1;
    localparam logic [7:0]  RST_QUANTUM1     = 8'd2;
    localparam logic [7:0]  RST_QUANTUM2     = 8'd4;
    localparam logic [6:0]  RST_MIN_SHARE    = 7'd20;

    typedef struct packed {
        logic [2:0] mode;
        logic [5:0] slot;
        logic [6:0] share;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] chosen_slot;
        logic       chosen_policy;
        logic [1:0] chosen_level;
    } t_out;

endpackage
`default_nettype wire

// File: rtl/mlfqss_div.sv
`timescale 1ns / 1ps
`default_nettype none
module mlfqss_div
    import mlfqss_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [6:0]             i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [FRAC_BITS+7:0]        o_quot
);
    localparam int DW = FRAC_BITS + 7;
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-1:0] DIVIDEND = DW'(FULL_SHARE) << FRAC_BITS;

    logic          r_busy, r_done, r_zero;
    logic [CW-1:0] r_cnt;
    logic [6:0]    r_rem, r_dsr;
    logic [DW-1:0] r_dvd, r_q;
    logic [7:0]    rem_sh;
    logic          ge;

    assign rem_sh = {r_rem, r_dvd[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_zero <= (i_divisor == 7'd0);
                r_dsr  <= i_divisor;
                r_rem  <= '0;
                r_dvd  <= DIVIDEND;
                r_q    <= '0;
                r_cnt  <= '0;
                if (i_divisor == 7'd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? 7'(rem_sh - {1'b0, r_dsr}) : rem_sh[6:0];
                r_dvd <= r_dvd << 1;
                r_q   <= {r_q[DW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_zero ? '1 : {1'b0, r_q};
endmodule
`default_nettype wire

// File: rtl/mlfqss_sat_add.sv
`timescale 1ns / 1ps
`default_nettype none
module mlfqss_sat_add
    import mlfqss_pkg::*;
#(
    parameter int W = DEF_FRAC_BITS + 24
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic [W-1:0]      o_sum
);
    logic [W:0] sum;
    assign sum   = {1'b0, i_a} + {1'b0, i_b};
    assign o_sum = sum[W] ? '1 : sum[W-1:0];
endmodule
`default_nettype wire

// File: rtl/mlfq_stride_scheduler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Combined MLFQ and stride scheduler over NUM_SLOTS task slots. Commands are taken one at a
// time; o_in_stall stays high until the result beat is loaded into the output register.
// Admit, block, wake and a rejected command do not use the divider. Set share and exit run the
// shared bit-serial divider, once per stride: twice for set share and once for exit. A schedule
// command walks the slot memory one entry per cycle through its single read port and then
// updates the winner through one shared saturating adder. No clearing pass.
module mlfq_stride_scheduler_core
    import mlfqss_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in        i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out            o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int SW       = $clog2(NUM_SLOTS);
    localparam int STRIDE_W = FRAC_BITS + 8;
    localparam int PASS_W   = FRAC_BITS + 24;

    typedef struct packed {
        logic [1:0]          level;
        logic [31:0]         rank;
        logic [7:0]          ticks;
        logic [6:0]          share;
        logic [STRIDE_W-1:0] stride;
        logic [PASS_W-1:0]   pass;
    } t_rec;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CMD   = 11'b00000000010,
        S_SHR   = 11'b00000000100,
        S_DIV1  = 11'b00000001000,
        S_DIV2  = 11'b00000010000,
        S_SCHED = 11'b00000100000,
        S_SCAN  = 11'b00001000000,
        S_TAIL  = 11'b00010000000,
        S_UPD   = 11'b00100000000,
        S_UPD2  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;

    logic [15:0] r_boost_period;
    logic [7:0]  r_allot0, r_allot1, r_quantum0, r_quantum1, r_quantum2;
    logic [6:0]  r_min_share;

    logic [NUM_SLOTS-1:0] r_in_use, r_runnable, r_is_stride, r_pass_ok;
    t_rec                 r_mem [NUM_SLOTS];
    t_rec                 r_rdata;

    logic [6:0]          r_share_left;
    logic [STRIDE_W-1:0] r_stride_q;
    logic [PASS_W-1:0]   r_mq_pass, r_total;
    logic [15:0]         r_boost_count;
    logic [31:0]         r_top_rank;

    t_in         r_in;
    logic [SW-1:0] r_idx;
    t_out        r_res, r_out;
    logic        r_ovld;

    logic          r_pol, r_boost, r_found, r_eval_vld;
    logic [SW-1:0] r_scan_idx, r_eval_idx, r_best_idx;
    t_rec          r_best;

    logic [SW-1:0] idx, rd_addr, mem_wa;
    logic          slot_ok, used, mem_we;
    t_rec          mem_wd;

    logic          div_start, div_busy, div_done;
    logic [6:0]    div_dsr;
    logic [STRIDE_W-1:0] div_quot;

    logic [PASS_W-1:0] add_a, add_b, add_sum;

    logic [7:0] avail, exit_sum;
    logic [6:0] exit_left;
    logic       reject;

    logic       act, elig, better;
    t_rec       cand;

    logic [7:0]  upd_ticks, upd_allot, upd_quant;
    logic [1:0]  upd_level;
    logic        upd_bump;
    logic [31:0] upd_top;
    t_rec        upd_rec;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    assign idx     = SW'(r_in.slot);
    assign slot_ok = (32'(r_in.slot) < NUM_SLOTS);
    assign used    = slot_ok && r_in_use[idx];

    assign avail     = {1'b0, r_share_left} + {1'b0, r_rdata.share};
    assign reject    = (r_in.share == 7'd0) || (avail < {1'b0, r_in.share}) ||
                       (8'(avail - {1'b0, r_in.share}) < {1'b0, r_min_share});
    assign exit_sum  = avail;
    assign exit_left = (exit_sum > 8'(FULL_SHARE)) ? 7'(FULL_SHARE) : exit_sum[6:0];

    // candidate view of the entry under evaluation, boost applied and stale pass cleared
    assign act = r_in_use[r_eval_idx] && r_runnable[r_eval_idx];
    always_comb begin
        cand = r_rdata;
        if (r_boost && act) begin
            cand.level = 2'd0;
            cand.ticks = 8'd0;
        end
        if (!r_pass_ok[r_eval_idx]) cand.pass = '0;
    end
    assign elig = act && (r_is_stride[r_eval_idx] == r_pol);
    always_comb begin
        if (!r_found) begin
            better = 1'b1;
        end else if (r_pol) begin
            better = cand.pass < r_best.pass;
        end else begin
            better = (cand.level < r_best.level) ||
                     ((cand.level == r_best.level) && (cand.rank < r_best.rank));
        end
    end

    // MLFQ winner update
    always_comb begin
        upd_ticks = (r_best.ticks == 8'hFF) ? 8'hFF : 8'(r_best.ticks + 1'b1);
        upd_allot = (r_best.level == 2'd0) ? r_allot0 : r_allot1;
        unique case (r_best.level)
            2'd0:    upd_quant = r_quantum0;
            2'd1:    upd_quant = r_quantum1;
            default: upd_quant = r_quantum2;
        endcase
        upd_top   = (r_top_rank == 32'hFFFF_FFFF) ? r_top_rank : 32'(r_top_rank + 1'b1);
        upd_level = r_best.level;
        upd_bump  = 1'b0;
        upd_rec   = r_best;
        if (r_best.level < 2'd2 && upd_ticks >= upd_allot) begin
            upd_level     = 2'(r_best.level + 1'b1);
            upd_rec.ticks = 8'd0;
        end else begin
            upd_rec.ticks = upd_ticks;
            upd_bump      = (upd_ticks >= upd_quant);
        end
        upd_rec.level = upd_level;
        if (upd_bump) upd_rec.rank = upd_top;
    end

    always_comb begin
        rd_addr = (r_state == S_SCAN) ? r_scan_idx : idx;
        mem_we  = 1'b0;
        mem_wa  = r_eval_idx;
        mem_wd  = cand;
        unique case (r_state)
            S_CMD: begin
                mem_we = (r_in.mode == MODE_ADMIT) && !used && slot_ok;
                mem_wa = idx;
                mem_wd = '0;
            end
            S_DIV1: begin
                mem_we        = div_done;
                mem_wa        = r_idx;
                mem_wd        = '0;
                mem_wd.share  = r_in.share;
                mem_wd.stride = div_quot;
            end
            S_SCAN, S_TAIL: begin
                mem_we = r_eval_vld && r_boost && act;
            end
            S_UPD: begin
                mem_we = r_found;
                mem_wa = r_best_idx;
                mem_wd = r_pol ? r_best : upd_rec;
                if (r_pol) mem_wd.pass = add_sum;
            end
            default: ;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_dsr   = r_share_left;
        if (r_state == S_SHR && (r_in.mode == MODE_EXIT || !reject)) begin
            div_start = 1'b1;
            div_dsr   = (r_in.mode == MODE_EXIT) ? exit_left : r_in.share;
        end else if (r_state == S_DIV1 && div_done) begin
            div_start = 1'b1;
        end
    end

    always_comb begin
        if (r_state == S_UPD2) begin
            add_a = r_total;
            add_b = PASS_W'(r_best.stride);
        end else if (r_pol) begin
            add_a = r_best.pass;
            add_b = PASS_W'(r_best.stride);
        end else begin
            add_a = r_mq_pass;
            add_b = PASS_W'(r_stride_q);
        end
    end

    mlfqss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (div_dsr),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    mlfqss_sat_add #(.W(PASS_W)) u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .o_sum (add_sum)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boost_period <= RST_BOOST_PERIOD;
            r_allot0       <= RST_ALLOT0;
            r_allot1       <= RST_ALLOT1;
            r_quantum0     <= RST_QUANTUM0;
            r_quantum1     <= RST_QUANTUM1;
            r_quantum2     <= RST_QUANTUM2;
            r_min_share    <= RST_MIN_SHARE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BOOST_PERIOD: r_boost_period <= i_cfg_data;
                CFG_ALLOT0:       r_allot0       <= i_cfg_data[7:0];
                CFG_ALLOT1:       r_allot1       <= i_cfg_data[7:0];
                CFG_QUANTUM0:     r_quantum0     <= i_cfg_data[7:0];
                CFG_QUANTUM1:     r_quantum1     <= i_cfg_data[7:0];
                CFG_QUANTUM2:     r_quantum2     <= i_cfg_data[7:0];
                CFG_MIN_SHARE:    r_min_share    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_in_use      <= '0;
            r_runnable    <= '0;
            r_is_stride   <= '0;
            r_pass_ok     <= '0;
            r_share_left  <= 7'(FULL_SHARE);
            r_stride_q    <= '0;
            r_mq_pass     <= '0;
            r_total       <= '0;
            r_boost_count <= '0;
            r_top_rank    <= '0;
            r_ovld        <= 1'b0;
            r_eval_vld    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_res   <= '0;
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    r_idx <= idx;
                    if (r_in.mode == MODE_SCHED) begin
                        r_state <= S_SCHED;
                    end else if (used &&
                                 (r_in.mode == MODE_SHARE || r_in.mode == MODE_EXIT)) begin
                        r_state <= S_SHR;
                    end else begin
                        r_state <= S_OUT;
                    end
                    if (r_in.mode == MODE_ADMIT) begin
                        if (!used && slot_ok) begin
                            r_pass_ok        <= '0;
                            r_in_use[idx]    <= 1'b1;
                            r_runnable[idx]  <= 1'b1;
                            r_is_stride[idx] <= 1'b0;
                        end
                    end else if (r_in.mode != MODE_SCHED && r_in.mode <= MODE_EXIT) begin
                        if (!used) begin
                            r_res.status <= ST_NOT_USED;
                        end else if (r_in.mode == MODE_BLOCK) begin
                            r_runnable[idx] <= 1'b0;
                        end else if (r_in.mode == MODE_WAKE) begin
                            r_runnable[idx] <= 1'b1;
                        end
                    end
                end
                S_SHR: begin
                    if (r_in.mode == MODE_EXIT) begin
                        r_share_left       <= exit_left;
                        r_in_use[r_idx]    <= 1'b0;
                        r_runnable[r_idx]  <= 1'b0;
                        r_is_stride[r_idx] <= 1'b0;
                        r_state            <= S_DIV2;
                    end else if (reject) begin
                        r_res.status <= ST_REJECT;
                        r_state      <= S_OUT;
                    end else begin
                        r_share_left       <= 7'(avail - {1'b0, r_in.share});
                        r_is_stride[r_idx] <= 1'b1;
                        r_pass_ok[r_idx]   <= 1'b1;
                        r_state            <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) r_state <= S_DIV2;
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_stride_q <= div_quot;
                        if (r_in.mode == MODE_SHARE) begin
                            r_mq_pass <= '0;
                            r_total   <= '0;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_SCHED: begin
                    r_pol      <= !((r_share_left == 7'(FULL_SHARE)) ||
                                    (r_mq_pass <= r_total));
                    r_boost    <= ((r_share_left == 7'(FULL_SHARE)) ||
                                   (r_mq_pass <= r_total)) &&
                                  (r_boost_count >= r_boost_period);
                    if (((r_share_left == 7'(FULL_SHARE)) || (r_mq_pass <= r_total)) &&
                        (r_boost_count >= r_boost_period)) begin
                        r_boost_count <= '0;
                        r_top_rank    <= '0;
                    end
                    r_found    <= 1'b0;
                    r_scan_idx <= '0;
                    r_eval_vld <= 1'b0;
                    r_state    <= S_SCAN;
                end
                S_SCAN, S_TAIL: begin
                    if (r_eval_vld && elig && better) begin
                        r_found    <= 1'b1;
                        r_best     <= cand;
                        r_best_idx <= r_eval_idx;
                    end
                    r_eval_vld <= 1'b1;
                    r_eval_idx <= r_scan_idx;
                    r_scan_idx <= SW'(r_scan_idx + 1'b1);
                    if (r_state == S_TAIL) begin
                        r_state <= S_UPD;
                    end else if (r_scan_idx == SW'(NUM_SLOTS - 1)) begin
                        r_state <= S_TAIL;
                    end
                end
                S_UPD: begin
                    r_state <= (r_pol && r_found) ? S_UPD2 : S_OUT;
                    if (!r_found) r_res.status <= ST_NONE;
                    if (!r_pol) begin
                        r_mq_pass <= add_sum;
                        if (r_found) begin
                            if (r_boost_count != 16'hFFFF) r_boost_count <= r_boost_count + 1'b1;
                            if (upd_bump) r_top_rank <= upd_top;
                            r_res.chosen_slot  <= 6'(r_best_idx);
                            r_res.chosen_level <= upd_level;
                        end
                    end else if (r_found) begin
                        r_pass_ok[r_best_idx] <= 1'b1;
                        r_res.chosen_slot     <= 6'(r_best_idx);
                        r_res.chosen_policy   <= 1'b1;
                    end
                end
                S_UPD2: begin
                    r_total <= add_sum;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovld || !i_out_stall) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_OUT && (!r_ovld || !i_out_stall)) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_share_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_share_left <= 7'(FULL_SHARE))
        else $error("mlfq share above full");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |->
        (o_out_data.chosen_slot == 6'd0) && !o_out_data.chosen_policy &&
        (o_out_data.chosen_level == 2'd0))
        else $error("failed beat carries a grant");

    a_stride_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.chosen_policy |-> o_out_data.chosen_level == 2'd0)
        else $error("stride grant with nonzero level");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIV1) || (r_state == S_DIV2))
        else $error("divider busy outside share update");
`endif
endmodule
`default_nettype wire

// File: tb/sv/tb_mlfq_stride_scheduler_core.sv
`timescale 1ns / 1ps
module tb_mlfq_stride_scheduler_core;
    import mlfqss_pkg::*;

    localparam int NSLOT = 64;
    localparam logic [23:0] STRIDE_ALL = 24'hFF_FFFF;
    localparam logic [39:0] PASS_ALL = 40'hFF_FFFF_FFFF;
    localparam int WATCH_LIMIT = 5000;
    localparam int LONG_HOLD = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    mlfq_stride_scheduler_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // scheduler shadow state
    logic [15:0] r_boost_period;
    logic [7:0]  r_allot0, r_allot1, r_quant0, r_quant1, r_quant2;
    logic [6:0]  r_min_share;
    logic        sl_used [NSLOT];
    logic        sl_run [NSLOT];
    logic        sl_strd [NSLOT];
    logic [1:0]  sl_level [NSLOT];
    logic [31:0] sl_rank [NSLOT];
    logic [7:0]  sl_ticks [NSLOT];
    logic [6:0]  sl_share [NSLOT];
    logic [23:0] sl_stride [NSLOT];
    logic [39:0] sl_pass [NSLOT];
    logic [6:0]  mlfq_left;
    logic [23:0] mq_stride;
    logic [39:0] mq_pass, stride_total;
    logic [15:0] boost_cnt;
    logic [31:0] rank_top;

    t_in  pending_cmds [$];
    t_out sched_expect [$];
    int   idle_max;
    int   n_results;
    bit   failed;
    bit   in_fire, out_fire;
    int   in_gap, stall_left;

    function automatic logic [39:0] pass_sat(logic [39:0] a, logic [23:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[40] ? PASS_ALL : s[39:0];
    endfunction

    function automatic logic [23:0] stride_for(logic [6:0] pct);
        if (pct == 0) return STRIDE_ALL;
        return 24'((32'd100 << 16) / pct);
    endfunction

    function automatic void free_slot(int i);
        sl_used[i] = 0; sl_run[i] = 0; sl_strd[i] = 0; sl_level[i] = 0;
        sl_rank[i] = 0; sl_ticks[i] = 0; sl_share[i] = 0; sl_stride[i] = 0;
        sl_pass[i] = 0;
    endfunction

    function automatic void rotate(int i);
        if (rank_top != 32'hFFFF_FFFF) rank_top++;
        sl_rank[i] = rank_top;
    endfunction

    function automatic void reset_model();
        r_boost_period = RST_BOOST_PERIOD; r_allot0 = RST_ALLOT0; r_allot1 = RST_ALLOT1;
        r_quant0 = RST_QUANTUM0; r_quant1 = RST_QUANTUM1; r_quant2 = RST_QUANTUM2;
        r_min_share = RST_MIN_SHARE;
        for (int i = 0; i < NSLOT; i++) free_slot(i);
        mlfq_left = 7'(FULL_SHARE); mq_stride = 0; mq_pass = 0; stride_total = 0;
        boost_cnt = 0; rank_top = 0;
    endfunction

    function automatic t_out grant_tick();
        t_out r;
        int best;
        bit found;
        r = '0;
        best = 0;
        found = 0;
        if (mlfq_left == FULL_SHARE || mq_pass <= stride_total) begin
            if (boost_cnt >= r_boost_period) begin
                for (int i = 0; i < NSLOT; i++)
                    if (sl_used[i] && sl_run[i]) begin
                        sl_level[i] = 0; sl_ticks[i] = 0;
                    end
                boost_cnt = 0;
                rank_top = 0;
            end
            for (int i = 0; i < NSLOT; i++) begin
                if (!sl_used[i] || !sl_run[i] || sl_strd[i]) continue;
                if (!found || sl_level[i] < sl_level[best] ||
                    (sl_level[i] == sl_level[best] && sl_rank[i] < sl_rank[best])) begin
                    best = i; found = 1;
                end
            end
            if (found) begin
                if (sl_ticks[best] != 8'd255) sl_ticks[best]++;
                if (boost_cnt != 16'hFFFF) boost_cnt++;
                case (sl_level[best])
                    2'd0: begin
                        if (sl_ticks[best] >= r_allot0) begin
                            sl_level[best] = 1; sl_ticks[best] = 0;
                        end else if (sl_ticks[best] >= r_quant0) rotate(best);
                    end
                    2'd1: begin
                        if (sl_ticks[best] >= r_allot1) begin
                            sl_level[best] = 2; sl_ticks[best] = 0;
                        end else if (sl_ticks[best] >= r_quant1) rotate(best);
                    end
                    default: if (sl_ticks[best] >= r_quant2) rotate(best);
                endcase
                r.chosen_slot = best[5:0];
                r.chosen_level = sl_level[best];
            end else begin
                r.status = ST_NONE;
            end
            mq_pass = pass_sat(mq_pass, mq_stride);
        end else begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!sl_used[i] || !sl_run[i] || !sl_strd[i]) continue;
                if (!found || sl_pass[i] < sl_pass[best]) begin
                    best = i; found = 1;
                end
            end
            if (!found) begin
                r.status = ST_NONE;
            end else begin
                sl_pass[best] = pass_sat(sl_pass[best], sl_stride[best]);
                stride_total = pass_sat(stride_total, sl_stride[best]);
                r.chosen_slot = best[5:0];
                r.chosen_policy = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_out apply_cmd(t_in c);
        t_out r;
        int s;
        int avail;
        r = '0;
        s = c.slot;
        if (c.mode == MODE_SCHED) return grant_tick();
        if (c.mode == MODE_ADMIT) begin
            if (!sl_used[s]) begin
                for (int i = 0; i < NSLOT; i++) sl_pass[i] = 0;
                free_slot(s);
                sl_used[s] = 1;
                sl_run[s] = 1;
            end
            return r;
        end
        if (c.mode > MODE_EXIT) return r;
        if (!sl_used[s]) begin
            r.status = ST_NOT_USED;
            return r;
        end
        case (c.mode)
            MODE_BLOCK: sl_run[s] = 0;
            MODE_WAKE:  sl_run[s] = 1;
            MODE_SHARE: begin
                avail = int'(mlfq_left) + int'(sl_share[s]);
                if (c.share == 0 || avail < int'(c.share) ||
                    avail - int'(c.share) < int'(r_min_share)) begin
                    r.status = ST_REJECT;
                    return r;
                end
                mlfq_left = 7'(avail - int'(c.share));
                sl_strd[s] = 1; sl_level[s] = 0; sl_rank[s] = 0; sl_ticks[s] = 0;
                sl_share[s] = c.share;
                sl_stride[s] = stride_for(c.share);
                sl_pass[s] = 0;
                mq_stride = stride_for(mlfq_left);
                mq_pass = 0;
                stride_total = 0;
            end
            default: begin
                avail = int'(mlfq_left) + int'(sl_share[s]);
                mlfq_left = (avail > FULL_SHARE) ? 7'(FULL_SHARE) : 7'(avail);
                mq_stride = stride_for(mlfq_left);
                free_slot(s);
            end
        endcase
        return r;
    endfunction

    // both handshakes sampled at the rising edge: retire a result, then predict
    always @(posedge i_clk) begin
        t_out want;
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        if (out_fire) begin
            n_results++;
            if (sched_expect.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, o_out_data);
                failed = 1;
            end else begin
                want = sched_expect.pop_front();
                if (want.status !== o_out_data.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_out_data.status);
                if (want.chosen_slot !== o_out_data.chosen_slot)
                    $display("%0t: chosen_slot expected %0d actual %0d", $time,
                             want.chosen_slot, o_out_data.chosen_slot);
                if (want.chosen_policy !== o_out_data.chosen_policy)
                    $display("%0t: chosen_policy expected %0d actual %0d", $time,
                             want.chosen_policy, o_out_data.chosen_policy);
                if (want.chosen_level !== o_out_data.chosen_level)
                    $display("%0t: chosen_level expected %0d actual %0d", $time,
                             want.chosen_level, o_out_data.chosen_level);
                if (want !== o_out_data) failed = 1;
            end
        end
        if (in_fire) sched_expect.push_back(apply_cmd(i_in_data));
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid) begin
                if (in_fire) begin
                    void'(pending_cmds.pop_front());
                    in_gap = $urandom_range(0, idle_max);
                    if (in_gap == 0 && pending_cmds.size() > 0) begin
                        i_in_data <= pending_cmds[0];
                    end else begin
                        i_in_valid <= 1'b0;
                    end
                end
            end else if (in_gap > 0) begin
                in_gap--;
            end else if (pending_cmds.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_cmds[0];
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_fire) begin
            stall_left = (n_results == 150) ? LONG_HOLD : $urandom_range(0, idle_max);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    int quiet;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) quiet = 0;
        else quiet++;
        if (quiet >= WATCH_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BOOST_PERIOD: r_boost_period = val;
            CFG_ALLOT0:       r_allot0 = val[7:0];
            CFG_ALLOT1:       r_allot1 = val[7:0];
            CFG_QUANTUM0:     r_quant0 = val[7:0];
            CFG_QUANTUM1:     r_quant1 = val[7:0];
            CFG_QUANTUM2:     r_quant2 = val[7:0];
            default:          r_min_share = val[6:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(int bp, int a0, int a1, int q0, int q1, int q2, int ms);
        cfg_write(CFG_BOOST_PERIOD, 16'(bp));
        cfg_write(CFG_ALLOT0, 16'(a0));
        cfg_write(CFG_ALLOT1, 16'(a1));
        cfg_write(CFG_QUANTUM0, 16'(q0));
        cfg_write(CFG_QUANTUM1, 16'(q1));
        cfg_write(CFG_QUANTUM2, 16'(q2));
        cfg_write(CFG_MIN_SHARE, 16'(ms));
    endtask

    task automatic cmd(logic [2:0] m, int s, int sh);
        t_in c;
        c.mode = m;
        c.slot = 6'(s);
        c.share = 7'(sh);
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || sched_expect.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_cmds(int n, int slot_span);
        int pick;
        int s;
        int sh;
        logic [2:0] m;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      m = MODE_SCHED;
            else if (pick < 55) m = MODE_ADMIT;
            else if (pick < 64) m = MODE_BLOCK;
            else if (pick < 75) m = MODE_WAKE;
            else if (pick < 87) m = MODE_SHARE;
            else if (pick < 96) m = MODE_EXIT;
            else                m = 3'($urandom_range(6, 7));
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                            : $urandom_range(0, slot_span);
            sh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(1, 40);
            cmd(m, s, sh);
        end
    endtask

    initial begin
        failed = 0;
        n_results = 0;
        in_fire = 0;
        out_fire = 0;
        in_gap = 0;
        stall_left = 0;
        quiet = 0;
        idle_max = 4;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        reset_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        cmd(MODE_SCHED, 0, 0);
        cmd(MODE_BLOCK, 40, 0);
        cmd(MODE_ADMIT, 0, 0);
        cmd(MODE_ADMIT, 63, 127);
        cmd(MODE_ADMIT, 63, 0);
        cmd(MODE_SCHED, 0, 0);
        cmd(MODE_SCHED, 0, 0);
        cmd(MODE_SHARE, 0, 0);
        cmd(MODE_SHARE, 0, 100);
        cmd(MODE_SHARE, 0, 80);
        cmd(MODE_SHARE, 63, 30);
        cmd(MODE_SHARE, 0, 40);
        cmd(MODE_SCHED, 0, 0);
        cmd(MODE_SCHED, 0, 0);
        cmd(MODE_SCHED, 0, 0);
        cmd(MODE_BLOCK, 63, 0);
        cmd(MODE_SCHED, 0, 0);
        cmd(MODE_WAKE, 63, 0);
        cmd(MODE_EXIT, 0, 0);
        cmd(MODE_EXIT, 0, 0);
        cmd(3'd6, 63, 127);
        cmd(3'd7, 42, 1);
        cmd(MODE_SCHED, 63, 0);
        drain();

        random_cmds(340, 7);
        drain();

        load_settings(1, 1, 1, 1, 1, 1, 0);
        random_cmds(340, 7);
        drain();

        idle_max = 0;
        load_settings(65535, 255, 255, 255, 255, 255, 100);
        random_cmds(340, 15);
        drain();

        idle_max = 4;
        load_settings($urandom_range(1, 40), $urandom_range(1, 8), $urandom_range(1, 12),
                      $urandom_range(1, 3), $urandom_range(1, 4), $urandom_range(1, 6),
                      $urandom_range(0, 60));
        random_cmds(340, 5);
        drain();

        load_settings(7, 3, 6, 2, 3, 5, 50);
        random_cmds(340, 63);
        drain();

        repeat (100) @(posedge i_clk);
        if (!failed) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
